FILE: rtl/video_block_edge_filter_macros.svh
// Assertion macros used by the edge filter top level.
`ifndef VIDEO_BLOCK_EDGE_FILTER_MACROS_SVH
`define VIDEO_BLOCK_EDGE_FILTER_MACROS_SVH

// Property checked outside of reset.
`define VBEF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define VBEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vbef_pkg.sv
package vbef_pkg;

    localparam int PIX_W       = 8;
    localparam int QP_W        = 5;
    localparam int MAX_LANES   = 8;
    localparam int DEF_LANES   = 8;
    localparam int ROW_W       = MAX_LANES * PIX_W;
    localparam int T_W         = 9;
    // quantizer followed by four rows, padded to whole bytes
    localparam int IN_TDATA_W  = ((QP_W + 4 * ROW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * ROW_W;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [QP_W-1:0]  t_qp;

    typedef enum logic {
        MODE_DEBLOCK = 1'b0,
        MODE_RRU     = 1'b1
    } t_filter_mode;

    // Per-item controls for the second lane stage.
    typedef struct packed {
        t_filter_mode mode;
        t_qp          qp;
    } t_s2_ctl;

    // Output register controls.
    typedef struct packed {
        logic load;
        logic taken;
    } t_out_ctl;

endpackage

FILE: rtl/vbef_lane.sv
module vbef_lane (
    input  logic              i_clk,
    input  logic              i_load,
    input  vbef_pkg::t_pixel  i_a,
    input  vbef_pkg::t_pixel  i_b,
    input  vbef_pkg::t_pixel  i_c,
    input  vbef_pkg::t_pixel  i_d,
    input  vbef_pkg::t_s2_ctl i_ctl,
    output vbef_pkg::t_pixel  o_before,
    output vbef_pkg::t_pixel  o_after
);
    import vbef_pkg::*;

    logic [12:0]    w_sum;
    logic [T_W-1:0] n_t;
    logic [T_W-1:0] r_t;
    t_pixel         r_b;
    t_pixel         r_c;

    logic           w_neg;
    logic [7:0]     w_mag;
    logic [QP_W-1:0] w_r;
    logic [9:0]     w_k;
    logic [9:0]     w_nb;
    logic [9:0]     w_nc;
    logic [9:0]     w_rb;
    logic [9:0]     w_rc;

    function automatic t_pixel clip_pixel(input logic [9:0] v);
        t_pixel res;
        if (v[9]) begin
            res = '0;
        end else if (v[8]) begin
            res = '1;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // 3A - 8B + 8C - 3D fits 13 bits two's complement; the floor shift by
    // four is then just the upper bits.
    assign w_sum = {5'b0, i_a} + {4'b0, i_a, 1'b0} + {2'b0, i_c, 3'b0}
                 - {2'b0, i_b, 3'b0} - {5'b0, i_d} - {4'b0, i_d, 1'b0};
    assign n_t   = w_sum[12:4];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_t <= n_t;
            r_b <= i_b;
            r_c <= i_c;
        end
    end

    assign w_neg = r_t[T_W-1];
    assign w_mag = w_neg ? 8'(~r_t + 9'd1) : r_t[7:0];

    always_comb begin
        if ({1'b0, w_mag, 1'b0} <= {5'b0, i_ctl.qp}) begin
            w_r = w_mag[QP_W-1:0];
        end else if ({1'b0, w_mag} <= {4'b0, i_ctl.qp}) begin
            w_r = i_ctl.qp - w_mag[QP_W-1:0];
        end else begin
            w_r = '0;
        end
    end

    assign w_k  = w_neg ? (10'd0 - {5'b0, w_r}) : {5'b0, w_r};
    assign w_nb = {2'b0, r_b} + w_k;
    assign w_nc = {2'b0, r_c} - w_k;
    assign w_rb = {2'b0, r_b} + {1'b0, r_b, 1'b0} + {2'b0, r_c} + 10'd2;
    assign w_rc = {2'b0, r_c} + {1'b0, r_c, 1'b0} + {2'b0, r_b} + 10'd2;

    always_comb begin
        if (i_ctl.mode == MODE_RRU) begin
            o_before = w_rb[9:2];
            o_after  = w_rc[9:2];
        end else begin
            o_before = clip_pixel(w_nb);
            o_after  = clip_pixel(w_nc);
        end
    end

endmodule

FILE: rtl/vbef_merge.sv
module vbef_merge #(
    parameter int LANES = vbef_pkg::MAX_LANES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vbef_pkg::t_out_ctl                 i_ctl,
    input  vbef_pkg::t_pixel [LANES-1:0]       i_before,
    input  vbef_pkg::t_pixel [LANES-1:0]       i_after,
    output logic                               o_valid,
    output logic [vbef_pkg::OUT_TDATA_W-1:0]   o_data
);
    import vbef_pkg::*;

    logic [ROW_W-1:0] w_before_row;
    logic [ROW_W-1:0] w_after_row;
    logic             r_valid;
    logic             n_valid;
    logic [OUT_TDATA_W-1:0] r_data;

    // Lanes past the configured count read as zero.
    for (genvar i = 0; i < MAX_LANES; i++) begin : g_pack
        if (i < LANES) begin : g_used
            assign w_before_row[i*PIX_W +: PIX_W] = i_before[i];
            assign w_after_row[i*PIX_W +: PIX_W]  = i_after[i];
        end else begin : g_unused
            assign w_before_row[i*PIX_W +: PIX_W] = '0;
            assign w_after_row[i*PIX_W +: PIX_W]  = '0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_valid = 1'b1;
        end else if (i_ctl.taken) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= {w_after_row, w_before_row};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/video_block_edge_filter.sv
// Block-edge smoothing filter, eight pixel lanes across one block edge.
// Input stream (s_axis): one transaction carries the quantizer and four
// pixel rows: two before the edge and two after it, one byte per lane.
// Output stream (m_axis): the two rows next to the edge, filtered.
// Config channel (i_cfg_*): one mode bit, 0 selects the quantizer-based
// deblocking filter, 1 selects reduced-resolution smoothing. Write it only
// while no transaction is in flight; o_cfg_ready is always high.
// The pipeline has two register stages: the lanes register the edge gradient
// and the merge stage registers the packed rows. An accepted transaction fills
// the lane registers first, then the output register behind m_axis_tvalid.
// Throughput is one transaction per cycle while m_axis_tready stays high; every
// lane works on its own pixel in parallel and nothing is iterated.
// Reset clears the mode to deblocking and empties both pipeline stages.
// When the receiver stalls, the output register holds its data and the
// first stage still fills, so two transactions are buffered before
// s_axis_tready drops.
module video_block_edge_filter #(
    parameter int LANES = vbef_pkg::DEF_LANES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data,      // filter_mode
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // quantizer[4:0], outer_before_row, near_before_row, near_after_row,
    // outer_after_row, zero pad
    input  logic [vbef_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // filtered_before_row[63:0], filtered_after_row[127:64]
    output logic [vbef_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import vbef_pkg::*;
    `include "video_block_edge_filter_macros.svh"

    localparam int ACT_LANES = (LANES > MAX_LANES) ? MAX_LANES : LANES;
    localparam int A_LO = QP_W;
    localparam int B_LO = QP_W + ROW_W;
    localparam int C_LO = QP_W + 2 * ROW_W;
    localparam int D_LO = QP_W + 3 * ROW_W;

    t_filter_mode r_mode;
    logic         r_s1_valid;
    logic         n_s1_valid;
    t_s2_ctl      r_s2_ctl;
    logic         w_out_ready;
    logic         w_s1_load;
    logic         w_in_fire;
    logic         w_busy;
    logic         w_s1_stall;
    logic         w_out_held;
    t_out_ctl     w_out_ctl;
    t_pixel [ACT_LANES-1:0] w_before;
    t_pixel [ACT_LANES-1:0] w_after;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DEBLOCK;
        end else if (i_cfg_valid) begin
            r_mode <= t_filter_mode'(i_cfg_data);
        end
    end

    assign w_out_ready   = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || w_out_ready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_s1_load     = w_in_fire;

    assign w_out_ctl.load  = r_s1_valid && w_out_ready;
    assign w_out_ctl.taken = m_axis_tvalid && m_axis_tready;

    assign w_busy     = r_s1_valid || m_axis_tvalid;
    assign w_s1_stall = r_s1_valid && !w_out_ready;
    assign w_out_held = m_axis_tvalid && !m_axis_tready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_fire) begin
            n_s1_valid = 1'b1;
        end else if (w_out_ctl.load) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s2_ctl.mode <= r_mode;
            r_s2_ctl.qp   <= s_axis_tdata[QP_W-1:0];
        end
    end

    for (genvar i = 0; i < ACT_LANES; i++) begin : g_lane
        vbef_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (w_s1_load),
            .i_a      (s_axis_tdata[A_LO + i*PIX_W +: PIX_W]),
            .i_b      (s_axis_tdata[B_LO + i*PIX_W +: PIX_W]),
            .i_c      (s_axis_tdata[C_LO + i*PIX_W +: PIX_W]),
            .i_d      (s_axis_tdata[D_LO + i*PIX_W +: PIX_W]),
            .i_ctl    (r_s2_ctl),
            .o_before (w_before[i]),
            .o_after  (w_after[i])
        );
    end

    vbef_merge #(
        .LANES (ACT_LANES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_out_ctl),
        .i_before (w_before),
        .i_after  (w_after),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata)
    );

    `VBEF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !w_busy, "pipeline busy after reset")
    `VBEF_ASSERT(a_accept_fills, i_clk, i_rst_n, w_in_fire |=> r_s1_valid, "transaction lost")
    `VBEF_ASSERT(a_stall_holds, i_clk, i_rst_n, w_s1_stall |=> $stable(r_s2_ctl), "stage moved")
    `VBEF_ASSERT(a_out_holds, i_clk, i_rst_n, w_out_held |=> $stable(m_axis_tdata), "data moved")

endmodule
